>>> hdl/cmd_pkg.sv
package cmd_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // field and register widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ENTRY_W    = 2 * PIX_W;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_DATA_W = 16;

    // width for column arithmetic: holds col + 2 and the width register
    localparam int EXT_W = (COL_W + 2 > IMG_W_W) ? COL_W + 2 : IMG_W_W;

    // reset values of the configuration registers
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(480);

    // configuration register indexes
    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // input beat kinds
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    // median of five by rank: ties broken by position, pick rank two
    function automatic logic [CH_W-1:0] med5(input logic [4:0][CH_W-1:0] v);
        logic [2:0]      rank [5];
        logic [CH_W-1:0] res;
        res = '0;
        for (int i = 0; i < 5; i++) begin
            rank[i] = 3'd0;
            for (int j = 0; j < 5; j++) begin
                if (j != i) begin
                    if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
                        rank[i] = rank[i] + 3'd1;
                    end
                end
            end
        end
        for (int i = 0; i < 5; i++) begin
            if (rank[i] == 3'd2) begin
                res = v[i];
            end
        end
        return res;
    endfunction

endpackage

>>> hdl/cmd_ram.sv
module cmd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_a,
    output logic [DATA_W-1:0]        o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // one write port, two registered read ports (read-first)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/cross_median_denoise_core.sv
// Median-of-five cross filter for an RGB raster stream. Pixels enter one beat per clock
// and each pixel of row r releases the filtered pixel of row r-1 at the same column, so
// the output runs one row behind; after the last pixel of the frame, flush beats drain
// the final row one pixel each, the last one marked with o_frame_end. Border pixels pass
// through unchanged. Sustained rate is one beat per cycle whenever the output side takes
// results. A beat's line store read is registered on acceptance; the median, write-back
// and output register load follow when the read stage advances, which waits while it
// holds a result and the output register is full and not taken. Both previous rows live
// in one line store of MAX_WIDTH entries with two registered read ports; the entry just
// written is forwarded to a read of the same entry in the same cycle. The line store
// needs no clearing after reset. Configuration writes are taken in any cycle.
module cross_median_denoise_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [cmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [cmd_pkg::CH_W-1:0]       i_red,
    input  logic [cmd_pkg::CH_W-1:0]       i_green,
    input  logic [cmd_pkg::CH_W-1:0]       i_blue,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cmd_pkg::CH_W-1:0]       o_out_red,
    output logic [cmd_pkg::CH_W-1:0]       o_out_green,
    output logic [cmd_pkg::CH_W-1:0]       o_out_blue,
    output logic                           o_frame_end
);

    localparam int COL_W   = cmd_pkg::COL_W;
    localparam int EXT_W   = cmd_pkg::EXT_W;
    localparam int CH_W    = cmd_pkg::CH_W;
    localparam int PIX_W   = cmd_pkg::PIX_W;
    localparam int ENTRY_W = cmd_pkg::ENTRY_W;
    localparam int H_W     = cmd_pkg::IMG_H_W;

    // configuration registers
    logic [cmd_pkg::IMG_W_W-1:0] r_image_width;
    logic [H_W-1:0]              r_image_height;

    // frame position
    logic [H_W-1:0]   r_row_count;
    logic [COL_W-1:0] r_col_count;
    logic [COL_W-1:0] r_drain_col;
    logic             r_draining;

    // read stage
    logic               r_s1_valid;
    logic               r_s1_flush;
    logic               r_s1_emit;
    logic               r_s1_interior;
    logic               r_s1_last;
    logic [PIX_W-1:0]   r_s1_px;
    logic [COL_W-1:0]   r_s1_addr;
    logic               r_fwd_a;
    logic               r_fwd_b;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic [PIX_W-1:0]   r_left;

    // output register
    logic             r_out_valid;
    logic [CH_W-1:0]  r_out_red;
    logic [CH_W-1:0]  r_out_green;
    logic [CH_W-1:0]  r_out_blue;
    logic             r_out_frame_end;

    // combinational
    logic               in_acc;
    logic               is_flush;
    logic               s1_load;
    logic               s1_free;
    logic               s1_adv;
    logic [EXT_W-1:0]   w_eff;
    logic [H_W-1:0]     h_eff;
    logic [EXT_W-1:0]   col_ext;
    logic               col_last;
    logic               drain_last;
    logic               row_last;
    logic               interior;
    logic [COL_W-1:0]   rd_addr_a;
    logic [COL_W-1:0]   rd_addr_b;
    logic [ENTRY_W-1:0] rd_data_a;
    logic [ENTRY_W-1:0] rd_data_b;
    logic [ENTRY_W-1:0] entry_c;
    logic [ENTRY_W-1:0] entry_r;
    logic [PIX_W-1:0]   center;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   right;
    logic [PIX_W-1:0]   med;
    logic [PIX_W-1:0]   result;
    logic               s1_we;
    logic [ENTRY_W-1:0] wr_data;

    // effective frame size
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = EXT_W'(1);
        end else if (EXT_W'(r_image_width) > EXT_W'(cmd_pkg::MAX_WIDTH)) begin
            w_eff = EXT_W'(cmd_pkg::MAX_WIDTH);
        end else begin
            w_eff = EXT_W'(r_image_width);
        end
        h_eff = (r_image_height == '0) ? H_W'(1) : r_image_height;
    end

    // position decisions for the beat at the input
    assign col_ext    = EXT_W'(r_col_count);
    assign col_last   = (col_ext + EXT_W'(1)) >= w_eff;
    assign drain_last = (EXT_W'(r_drain_col) + EXT_W'(1)) >= w_eff;
    assign row_last   = ((H_W + 1)'(r_row_count) + (H_W + 1)'(1)) >= (H_W + 1)'(h_eff);
    assign interior   = (r_row_count >= H_W'(2)) && (r_row_count < h_eff)
                        && (r_col_count != '0)
                        && ((col_ext + EXT_W'(2)) <= w_eff)
                        && ((col_ext + EXT_W'(1)) < EXT_W'(cmd_pkg::MAX_WIDTH));

    // handshake and pipeline flow
    assign is_flush   = (i_kind == cmd_pkg::KIND_FLUSH);
    assign s1_free    = !r_s1_valid || !r_s1_emit || !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && s1_free;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign s1_load    = in_acc && (is_flush ? r_draining : !r_draining);

    // line store: entry = {row two above, row above}
    assign rd_addr_a = is_flush ? r_drain_col : r_col_count;
    assign rd_addr_b = r_col_count + COL_W'(1);

    cmd_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (cmd_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_waddr   (r_s1_addr),
        .i_wdata   (wr_data),
        .i_re      (s1_load),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_a),
        .o_rdata_b (rd_data_b)
    );

    // forward an entry written in the read cycle
    assign entry_c = r_fwd_a ? r_fwd_data : rd_data_a;
    assign entry_r = r_fwd_b ? r_fwd_data : rd_data_b;
    assign center  = entry_c[PIX_W-1:0];
    assign top     = entry_c[ENTRY_W-1:PIX_W];
    assign right   = entry_r[PIX_W-1:0];

    // write-back shifts the column down one row
    assign s1_we   = s1_adv && !r_s1_flush;
    assign wr_data = {center, r_s1_px};

    // per-channel median of the cross
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            med[k*CH_W +: CH_W] = cmd_pkg::med5({center[k*CH_W +: CH_W],
                                                 r_left[k*CH_W +: CH_W],
                                                 right[k*CH_W +: CH_W],
                                                 top[k*CH_W +: CH_W],
                                                 r_s1_px[k*CH_W +: CH_W]});
        end
        result = (!r_s1_flush && r_s1_interior) ? med : center;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= cmd_pkg::IMG_W_RESET;
            r_image_height <= cmd_pkg::IMG_H_RESET;
            r_row_count    <= '0;
            r_col_count    <= '0;
            r_drain_col    <= '0;
            r_draining     <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (cmd_pkg::t_cfg_idx'(i_cfg_index))
                    cmd_pkg::CFG_IMAGE_WIDTH: begin
                        r_image_width <= i_cfg_data[cmd_pkg::IMG_W_W-1:0];
                    end
                    cmd_pkg::CFG_IMAGE_HEIGHT: begin
                        r_image_height <= i_cfg_data[H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // frame position
            if (in_acc) begin
                if (is_flush) begin
                    if (r_draining) begin
                        if (drain_last) begin
                            r_row_count <= '0;
                            r_col_count <= '0;
                            r_drain_col <= '0;
                            r_draining  <= 1'b0;
                        end else begin
                            r_drain_col <= r_drain_col + COL_W'(1);
                        end
                    end
                end else if (!r_draining) begin
                    if (col_last) begin
                        r_col_count <= '0;
                        if (row_last) begin
                            r_draining  <= 1'b1;
                            r_drain_col <= '0;
                        end else begin
                            r_row_count <= r_row_count + H_W'(1);
                        end
                    end else begin
                        r_col_count <= r_col_count + COL_W'(1);
                    end
                end
            end

            // read stage occupancy
            if (in_acc) begin
                r_s1_valid <= s1_load;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // output register occupancy
            if (s1_adv && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_flush    <= is_flush;
            r_s1_emit     <= is_flush || (r_row_count != '0);
            r_s1_interior <= interior;
            r_s1_last     <= is_flush && drain_last;
            r_s1_px       <= {i_red, i_green, i_blue};
            r_s1_addr     <= rd_addr_a;
            r_fwd_a       <= s1_we && (r_s1_addr == rd_addr_a);
            r_fwd_b       <= s1_we && (r_s1_addr == rd_addr_b);
            r_fwd_data    <= wr_data;
        end
        if (s1_we) begin
            r_left <= center;
        end
        if (s1_adv && r_s1_emit) begin
            r_out_red       <= result[2*CH_W +: CH_W];
            r_out_green     <= result[CH_W +: CH_W];
            r_out_blue      <= result[0 +: CH_W];
            r_out_frame_end <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_frame_end = r_out_frame_end;

    // drain always starts at the left edge of a row
    a_drain_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_col_count == '0))
        else $error("column counter not zero while draining");

    // the last drain beat in flight has already closed the frame
    a_last_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> !r_draining)
        else $error("frame end in flight while still draining");

    // draining starts only on an accepted pixel beat
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_draining) |-> $past(in_acc && !is_flush))
        else $error("drain started without a pixel beat");

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT     = 28;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_BEATS = 340;

    typedef struct packed {
        logic [cmd_pkg::CH_W-1:0] red;
        logic [cmd_pkg::CH_W-1:0] green;
        logic [cmd_pkg::CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb px;
        logic last;
    } t_filtered;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_index;
    logic [cmd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_kind;
    logic [cmd_pkg::CH_W-1:0]       i_red;
    logic [cmd_pkg::CH_W-1:0]       i_green;
    logic [cmd_pkg::CH_W-1:0]       i_blue;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [cmd_pkg::CH_W-1:0]       o_out_red;
    logic [cmd_pkg::CH_W-1:0]       o_out_green;
    logic [cmd_pkg::CH_W-1:0]       o_out_blue;
    logic                           o_frame_end;

    // shadow of the line stores, position counters and registers
    t_rgb                        line_last  [cmd_pkg::MAX_WIDTH];
    t_rgb                        line_older [cmd_pkg::MAX_WIDTH];
    int unsigned                 row_pos;
    int unsigned                 col_pos;
    int unsigned                 drain_pos;
    bit                          draining_now;
    logic [cmd_pkg::IMG_W_W-1:0] width_reg;
    logic [cmd_pkg::IMG_H_W-1:0] height_reg;

    t_filtered   pending_pixels [$];
    int unsigned beats_taken;
    int unsigned error_count;
    bit          steady_stretch;
    bit          hold_request;

    cross_median_denoise_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // median of five values of one channel
    function automatic logic [cmd_pkg::CH_W-1:0] channel_median(
        input logic [cmd_pkg::CH_W-1:0] a,
        input logic [cmd_pkg::CH_W-1:0] b,
        input logic [cmd_pkg::CH_W-1:0] c,
        input logic [cmd_pkg::CH_W-1:0] d,
        input logic [cmd_pkg::CH_W-1:0] e);
        logic [cmd_pkg::CH_W-1:0] v [5];
        logic [cmd_pkg::CH_W-1:0] pick;
        int                       below;
        int                       not_above;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        v[4] = e;
        pick = '0;
        for (int i = 0; i < 5; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < 5; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) not_above++;
            end
            if (below <= 2 && not_above >= 3) pick = v[i];
        end
        return pick;
    endfunction

    function automatic t_rgb cross_median(input t_rgb ctr, input t_rgb lft, input t_rgb rgt,
                                          input t_rgb top, input t_rgb bot);
        t_rgb res;
        res.red   = channel_median(ctr.red, lft.red, rgt.red, top.red, bot.red);
        res.green = channel_median(ctr.green, lft.green, rgt.green, top.green, bot.green);
        res.blue  = channel_median(ctr.blue, lft.blue, rgt.blue, top.blue, bot.blue);
        return res;
    endfunction

    function automatic void queue_result(input t_rgb px, input logic last);
        t_filtered item;
        item.px   = px;
        item.last = last;
        pending_pixels.push_back(item);
    endfunction

    function automatic void filter_reset();
        row_pos      = 0;
        col_pos      = 0;
        drain_pos    = 0;
        draining_now = 1'b0;
        width_reg    = cmd_pkg::IMG_W_RESET;
        height_reg   = cmd_pkg::IMG_H_RESET;
    endfunction

    // advance the filter by one accepted beat; returns 0 when the beat is ignored
    function automatic bit cross_median_step(input cmd_pkg::t_kind kind, input t_rgb px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit          interior;
        bit          last;
        t_rgb        res;
        if (width_reg == '0) w = 1;
        else if (32'(width_reg) > cmd_pkg::MAX_WIDTH) w = cmd_pkg::MAX_WIDTH;
        else w = 32'(width_reg);
        h = (height_reg == '0) ? 1 : 32'(height_reg);

        // flush beat drains one pixel of the last row
        if (kind == cmd_pkg::KIND_FLUSH) begin
            if (!draining_now) return 1'b0;
            c = (drain_pos < cmd_pkg::MAX_WIDTH) ? drain_pos : cmd_pkg::MAX_WIDTH - 1;
            last = (drain_pos + 1 >= w);
            queue_result(line_last[c], last);
            if (last) begin
                row_pos      = 0;
                col_pos      = 0;
                drain_pos    = 0;
                draining_now = 1'b0;
            end else begin
                drain_pos++;
            end
            return 1'b1;
        end

        if (draining_now) return 1'b0;

        // pixel beat releases the pixel one row up
        c = (col_pos < cmd_pkg::MAX_WIDTH) ? col_pos : cmd_pkg::MAX_WIDTH - 1;
        if (row_pos >= 1) begin
            res = line_last[c];
            interior = (row_pos >= 2) && (row_pos < h) && (c >= 1) && (c + 2 <= w)
                       && (c + 1 < cmd_pkg::MAX_WIDTH);
            if (interior) begin
                // left neighbor was already shifted into the older row
                res = cross_median(line_last[c], line_older[c - 1], line_last[c + 1],
                                   line_older[c], px);
            end
            queue_result(res, 1'b0);
        end
        line_older[c] = line_last[c];
        line_last[c]  = px;

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                draining_now = 1'b1;
                drain_pos    = 0;
            end else begin
                row_pos = (row_pos + 1) & 32'hFFFF;
            end
        end else begin
            col_pos++;
        end
        return 1'b1;
    endfunction

    // pixel mix: full range, a cluster around mid scale, and the extremes
    function automatic t_rgb random_pixel();
        t_rgb        p;
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 20) begin
            p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end else if (mode < 45) begin
            p.red   = 8'h7E + 8'($urandom_range(3));
            p.green = 8'h7E + 8'($urandom_range(3));
            p.blue  = 8'h7E + 8'($urandom_range(3));
        end else begin
            p.red   = 8'($urandom_range(255));
            p.green = 8'($urandom_range(255));
            p.blue  = 8'($urandom_range(255));
        end
        return p;
    endfunction

    // one input beat, with random idle cycles in front outside a steady stretch
    task automatic send_beat(input cmd_pkg::t_kind kind, input t_rgb px);
        if (!steady_stretch) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_red      <= px.red;
        i_green    <= px.green;
        i_blue     <= px.blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cross_median_step(kind, px)) beats_taken++;
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_beat(cmd_pkg::KIND_PIXEL, random_pixel());
    endtask

    // pixels until the frame is in, flush beats until drained; noise_pct adds ignored beats
    task automatic run_frame(input int unsigned noise_pct);
        do begin
            if ($urandom_range(99) < noise_pct)
                send_beat(draining_now ? cmd_pkg::KIND_PIXEL : cmd_pkg::KIND_FLUSH,
                          random_pixel());
            send_beat(draining_now ? cmd_pkg::KIND_FLUSH : cmd_pkg::KIND_PIXEL,
                      random_pixel());
        end while (draining_now || row_pos != 0 || col_pos != 0);
    endtask

    // stop sending, let every result come out and the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input cmd_pkg::t_cfg_idx idx,
                             input logic [cmd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == cmd_pkg::CFG_IMAGE_WIDTH) width_reg = data[cmd_pkg::IMG_W_W-1:0];
        else height_reg = data[cmd_pkg::IMG_H_W-1:0];
    endtask

    // 3x3 frame with extreme and tied channel values, plus ignored beats
    task automatic test_directed_corners();
        t_rgb grid [9];
        grid[0] = {8'h00, 8'hFF, 8'h80};
        grid[1] = {8'hFF, 8'h00, 8'h80};
        grid[2] = {8'h00, 8'h00, 8'h00};
        grid[3] = {8'h10, 8'hFF, 8'h7F};
        grid[4] = {8'hFF, 8'h00, 8'h81};
        grid[5] = {8'hFF, 8'hFF, 8'hFF};
        grid[6] = {8'hFF, 8'h00, 8'h80};
        grid[7] = {8'h00, 8'hFF, 8'h80};
        grid[8] = {8'h55, 8'hAA, 8'h01};
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd3);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        // flush with nothing to drain
        send_beat(cmd_pkg::KIND_FLUSH, {8'hFF, 8'hFF, 8'hFF});
        for (int i = 0; i < 9; i++) send_beat(cmd_pkg::KIND_PIXEL, grid[i]);
        // pixel while the last row drains
        send_beat(cmd_pkg::KIND_PIXEL, {8'hA5, 8'h5A, 8'hC3});
        repeat (3) send_beat(cmd_pkg::KIND_FLUSH, {8'h00, 8'h00, 8'h00});
    endtask

    // width and height codes of zero, and a two-column frame
    task automatic test_degenerate_sizes();
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd0);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        send_beat(cmd_pkg::KIND_PIXEL, {8'h12, 8'h34, 8'h56});
        send_beat(cmd_pkg::KIND_PIXEL, {8'hED, 8'hCB, 8'hA9});
        send_beat(cmd_pkg::KIND_FLUSH, {8'h00, 8'h00, 8'h00});
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd2);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd4);
        run_frame(0);
    endtask

    // register writes partway through a frame
    task automatic test_midframe_changes();
        // narrow the rows in the middle of the third row
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd8);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd6);
        send_pixels(22);
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd4);
        run_frame(0);
        // grow the frame by two rows
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd3);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        send_pixels(5);
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd5);
        run_frame(0);
        // cut a very tall frame short, rows past the new height are border rows
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
        send_pixels(12);
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        run_frame(0);
    endtask

    // output held off for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd16);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd10);
        hold_request = 1'b1;
        run_frame(0);
    endtask

    // width code above the line store size wraps the first row at the full line store,
    // then a narrow second row releases its start
    task automatic test_widest_frame();
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        send_pixels(cmd_pkg::MAX_WIDTH);
        wait_idle();
        write_reg(cmd_pkg::CFG_IMAGE_WIDTH, 16'd3);
        run_frame(0);
    endtask

    // random frames of mostly small sizes with a few ignored beats mixed in
    task automatic test_random_frames();
        int unsigned                    start;
        int unsigned                    done_here;
        int unsigned                    w;
        int unsigned                    h;
        logic [cmd_pkg::CFG_DATA_W-1:0] data;
        bit                             first;
        start = beats_taken;
        first = 1'b1;
        done_here = 0;
        while (done_here < RANDOM_BEATS) begin
            if (first || $urandom_range(1) == 0) begin
                if ($urandom_range(9) == 0) begin
                    w = $urandom_range(64, 13);
                    h = $urandom_range(6, 2);
                end else begin
                    w = $urandom_range(12, 0);
                    h = $urandom_range(8, 0);
                end
                wait_idle();
                data = 16'($urandom);
                data[cmd_pkg::IMG_W_W-1:0] = w[cmd_pkg::IMG_W_W-1:0];
                write_reg(cmd_pkg::CFG_IMAGE_WIDTH, data);
                write_reg(cmd_pkg::CFG_IMAGE_HEIGHT, 16'(h));
                first = 1'b0;
            end
            // one stretch with no idling on either side
            steady_stretch = (done_here >= 60 && done_here < 260);
            run_frame(5);
            done_here = beats_taken - start;
        end
        steady_stretch = 1'b0;
    endtask

    // output side: random stalls, long hold on request, result checks
    initial begin : result_monitor
        int unsigned hold_left;
        t_filtered   want;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result beat: %0d %0d %0d frame_end %0d",
                           o_out_red, o_out_green, o_out_blue, o_frame_end);
                    error_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_red !== want.px.red) begin
                        $error("out_red: expected %0d, actual %0d", want.px.red, o_out_red);
                        error_count++;
                    end
                    if (o_out_green !== want.px.green) begin
                        $error("out_green: expected %0d, actual %0d", want.px.green,
                               o_out_green);
                        error_count++;
                    end
                    if (o_out_blue !== want.px.blue) begin
                        $error("out_blue: expected %0d, actual %0d", want.px.blue, o_out_blue);
                        error_count++;
                    end
                    if (o_frame_end !== want.last) begin
                        $error("frame_end: expected %0d, actual %0d", want.last, o_frame_end);
                        error_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // run length guard
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL cross_median_denoise_core");
        $finish;
    end

    // reset, tests in turn, final report
    initial begin : stimulus
        int unsigned settle;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = cmd_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = cmd_pkg::KIND_PIXEL;
        i_red          = '0;
        i_green        = '0;
        i_blue         = '0;
        steady_stretch = 1'b0;
        hold_request   = 1'b0;
        error_count    = 0;
        beats_taken    = 0;
        filter_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_degenerate_sizes();
        test_midframe_changes();
        test_output_backpressure();
        test_widest_frame();
        test_random_frames();

        i_in_valid <= 1'b0;
        settle = 0;
        while (pending_pixels.size() != 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d filtered pixels never came out", pending_pixels.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS cross_median_denoise_core");
        end else begin
            $display("FAIL cross_median_denoise_core");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cmd_pkg.sv
hdl/cmd_ram.sv
hdl/cross_median_denoise_core.sv
tb/testbench.sv
